// ===== rtl/crfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the comet ring frame renderer.
// No dependencies; every other file imports this package.
package crfr_pkg;

  localparam int PIX_W    = 6;          // pixel index and distance width
  localparam int CHAN_W   = 8;          // colour channel, brightness width
  localparam int SEL_W    = 3;          // palette index width
  localparam int CFG_AW   = 3;          // APB byte address width
  localparam int CFG_DW   = 32;         // APB data width

  localparam logic [CHAN_W-1:0] SCALE_RESET = 8'd50;

  // Register word indexes on the configuration port.
  localparam logic REG_GAIN = 1'b0;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam rgb_t PALETTE [8] = '{
    '{8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd165, 8'd0},
    '{8'd128, 8'd0,   8'd255},
    '{8'd0,   8'd255, 8'd200},
    '{8'd255, 8'd255, 8'd0},
    '{8'd255, 8'd20,  8'd147}
  };

  // One classified frame command waiting for the renderer.
  typedef struct packed {
    logic [PIX_W-1:0]  dist0;  // distance of pixel 0 from the head
    logic [CHAN_W-1:0] br;     // scaled head brightness
    logic [SEL_W-1:0]  sel;    // palette entry
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/crfr_front.sv =====
`timescale 1ns / 1ps
// Front end: APB brightness scale register, frame command intake and
// classification into a queue entry. Depends on crfr_pkg.
module crfr_front #(
  parameter int RING_PIXELS = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [crfr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [crfr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [crfr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_head_position,
  input  logic [7:0]                    in_frame_brightness,
  input  logic [7:0]                    in_color_select,
  input  crfr_pkg::q_status_t           q_status,
  output logic                          q_push,
  output crfr_pkg::cmd_t                q_wdata
);
  import crfr_pkg::*;

  logic [CHAN_W-1:0]   scale_r;
  logic                cfg_wr;
  logic [2*CHAN_W-1:0] br_prod;
  logic [PIX_W-1:0]    pos_tbl [256];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1] == REG_GAIN);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_GAIN) ?
                      CFG_DW'(scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr) begin
      scale_r <= cfg_pwdata[CHAN_W-1:0];
    end
  end

  // Head position modulo ring size, as an elaborated lookup table.
  for (genvar g = 0; g < 256; g++) begin : g_pos_tbl
    assign pos_tbl[g] = PIX_W'(g % RING_PIXELS);
  end

  assign br_prod  = in_frame_brightness * scale_r;
  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata.dist0 = pos_tbl[in_head_position];
    q_wdata.br    = br_prod[2*CHAN_W-1:CHAN_W];
    q_wdata.sel   = in_color_select[SEL_W-1:0];
  end

endmodule

// ===== rtl/crfr_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between front and back ends.
// Depends on crfr_pkg.
module crfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  crfr_pkg::cmd_t      wdata,
  input  logic                pop,
  output crfr_pkg::cmd_t      rdata,
  output crfr_pkg::q_status_t status
);
  import crfr_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign rdata        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/crfr_back.sv =====
`timescale 1ns / 1ps
// Back end: pixel sequencer and pixel pipeline (square, cube, scale, 8-stage
// restoring divider, fade level, palette multiply, output register).
// Depends on crfr_pkg.
module crfr_back #(
  parameter int RING_PIXELS = 35
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  crfr_pkg::cmd_t              q_rdata,
  input  crfr_pkg::q_status_t         q_status,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crfr_pkg::PIX_W-1:0]  out_pixel_number,
  output logic [7:0]                  out_green_level,
  output logic [7:0]                  out_red_level,
  output logic [7:0]                  out_blue_level,
  output logic                        out_last_pixel
);
  import crfr_pkg::*;

  localparam int SQ_W   = 2 * PIX_W;
  localparam int CUBE_W = 3 * PIX_W;
  localparam int X_W    = CUBE_W + CHAN_W;
  localparam int DIV_STAGES = CHAN_W;
  localparam logic [X_W-1:0] SPAN3 =
    X_W'((RING_PIXELS - 1) * (RING_PIXELS - 1) * (RING_PIXELS - 1));
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(RING_PIXELS - 1);

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [CHAN_W-1:0] br;
    logic [SEL_W-1:0]  sel;
    logic              last;
  } ctx_t;

  logic              adv;
  logic              issue;
  logic              last_issue;
  logic [PIX_W-1:0]  pix_cnt_r;
  logic [PIX_W-1:0]  dist_r;
  logic [PIX_W-1:0]  dist_cur;

  logic              s1_vld_r;
  ctx_t              s1_ctx_r;
  logic [PIX_W-1:0]  s1_d_r;
  logic [SQ_W-1:0]   s1_sq_r;

  logic              s2_vld_r;
  ctx_t              s2_ctx_r;
  logic [CUBE_W-1:0] s2_cube_r;

  logic              dv_vld_r [DIV_STAGES+1];
  ctx_t              dv_ctx_r [DIV_STAGES+1];
  logic [X_W-1:0]    dv_rem_r [DIV_STAGES+1];
  logic [CHAN_W-1:0] dv_q_r   [DIV_STAGES+1];

  logic              lv_vld_r;
  ctx_t              lv_ctx_r;
  logic [CHAN_W-1:0] lv_level_r;

  rgb_t              base;
  logic [2*CHAN_W-1:0] g_prod;
  logic [2*CHAN_W-1:0] r_prod;
  logic [2*CHAN_W-1:0] b_prod;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [CHAN_W-1:0] out_g_r;
  logic [CHAN_W-1:0] out_r_r;
  logic [CHAN_W-1:0] out_b_r;
  logic              out_last_r;

  // The whole pipeline advances together unless the output is held.
  assign adv        = !out_valid_r || out_ready;
  assign issue      = adv && !q_status.empty;
  assign last_issue = (pix_cnt_r == LAST_PIX);
  assign q_pop      = issue && last_issue;
  assign dist_cur   = (pix_cnt_r == '0) ? q_rdata.dist0 : dist_r;

  // Pixel sequencer: walk the ring, distance steps down with wrap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= '0;
    end else if (issue) begin
      pix_cnt_r <= last_issue ? '0 : pix_cnt_r + PIX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      dist_r <= (dist_cur == '0) ? LAST_PIX : dist_cur - PIX_W'(1);
    end
  end

  // Stage 1: square of the distance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx_r.pix  <= pix_cnt_r;
      s1_ctx_r.br   <= q_rdata.br;
      s1_ctx_r.sel  <= q_rdata.sel;
      s1_ctx_r.last <= last_issue;
      s1_d_r        <= dist_cur;
      s1_sq_r       <= SQ_W'(dist_cur) * SQ_W'(dist_cur);
    end
  end

  // Stage 2: cube.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctx_r  <= s1_ctx_r;
      s2_cube_r <= CUBE_W'(s1_sq_r) * CUBE_W'(s1_d_r);
    end
  end

  // Stage 3: dividend = cube * brightness.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx_r[0] <= s2_ctx_r;
      dv_rem_r[0] <= X_W'(s2_cube_r) * X_W'(s2_ctx_r.br);
      dv_q_r[0]   <= '0;
    end
  end

  // Restoring divider by (RING_PIXELS-1)^3, one quotient bit per stage.
  // The quotient never exceeds the brightness, so eight bits suffice.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam logic [X_W-1:0] DIVISOR_K = SPAN3 << (DIV_STAGES - 1 - g);
    logic           take;
    logic [X_W-1:0] rem_nxt;

    assign take    = (dv_rem_r[g] >= DIVISOR_K);
    assign rem_nxt = take ? dv_rem_r[g] - DIVISOR_K : dv_rem_r[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[g+1] <= dv_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctx_r[g+1] <= dv_ctx_r[g];
        dv_rem_r[g+1] <= rem_nxt;
        dv_q_r[g+1]   <= {dv_q_r[g][CHAN_W-2:0], take};
      end
    end
  end

  // Fade level, clamped at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_vld_r <= 1'b0;
    end else if (adv) begin
      lv_vld_r <= dv_vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lv_ctx_r   <= dv_ctx_r[DIV_STAGES];
      lv_level_r <= (dv_q_r[DIV_STAGES] > dv_ctx_r[DIV_STAGES].br) ? '0 :
                    dv_ctx_r[DIV_STAGES].br - dv_q_r[DIV_STAGES];
    end
  end

  // Palette colour scaled by the level, one multiplier per channel.
  assign base   = PALETTE[lv_ctx_r.sel];
  assign g_prod = base.green * lv_level_r;
  assign r_prod = base.red   * lv_level_r;
  assign b_prod = base.blue  * lv_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= lv_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r  <= lv_ctx_r.pix;
      out_g_r    <= g_prod[2*CHAN_W-1:CHAN_W];
      out_r_r    <= r_prod[2*CHAN_W-1:CHAN_W];
      out_b_r    <= b_prod[2*CHAN_W-1:CHAN_W];
      out_last_r <= lv_ctx_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_number = out_pix_r;
  assign out_green_level  = out_g_r;
  assign out_red_level    = out_r_r;
  assign out_blue_level   = out_b_r;
  assign out_last_pixel   = out_last_r;

endmodule

// ===== rtl/comet_ring_frame_renderer_top.sv =====
`timescale 1ns / 1ps
// Top level of the comet ring frame renderer: front end, command queue
// and back end. Depends on crfr_pkg, crfr_front, crfr_queue, crfr_back.
//
// Each accepted frame command (head position, peak brightness, palette
// selector) produces RING_PIXELS output transactions, pixel 0 first, the
// final one flagged by out_last_pixel. The renderer emits one pixel per
// clock unless the output is held or the queue is empty; the pixel
// sequencer in the back end walks the ring. Frames follow one another
// with no gap: a two-entry command queue lets the front end take the
// next frame command while the current frame is still being rendered.
// With the back end idle, a taken command passes the queue, square,
// cube, brightness product, eight divider stages, fade level and
// palette multiply into the output register before out_valid rises.
// Output back pressure holds the whole pixel pipeline in place; nothing
// is dropped. The brightness scale register (word 0 of the APB-style
// port, reset 50) is sampled when a command is accepted, so write it
// only while the block is idle.
module comet_ring_frame_renderer_top #(
  parameter int RING_PIXELS = 35
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [crfr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [crfr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [crfr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  // Frame command channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_head_position,
  input  logic [7:0]                  in_frame_brightness,
  input  logic [7:0]                  in_color_select,
  // Pixel channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crfr_pkg::PIX_W-1:0]  out_pixel_number,
  output logic [7:0]                  out_green_level,
  output logic [7:0]                  out_red_level,
  output logic [7:0]                  out_blue_level,
  output logic                        out_last_pixel
);
  import crfr_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_wdata;
  cmd_t      q_rdata;

  // Scale the brightness and reduce the head position on intake.
  crfr_front #(
    .RING_PIXELS (RING_PIXELS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_head_position    (in_head_position),
    .in_frame_brightness (in_frame_brightness),
    .in_color_select     (in_color_select),
    .q_status            (q_status),
    .q_push              (q_push),
    .q_wdata             (q_wdata)
  );

  // Hold classified commands until the back end has issued their last pixel.
  crfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // Walk the ring and render one pixel per cycle unless the output is held.
  crfr_back #(
    .RING_PIXELS (RING_PIXELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_status         (q_status),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_number (out_pixel_number),
    .out_green_level  (out_green_level),
    .out_red_level    (out_red_level),
    .out_blue_level   (out_blue_level),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== sim/comet_ring_frame_renderer_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for comet_ring_frame_renderer_top: drives frame commands,
// predicts every ring pixel and checks the pixel stream field by field.
// Depends on crfr_pkg and the renderer RTL only.
module comet_ring_frame_renderer_top_test;
  import crfr_pkg::*;

  localparam int RING_PIXELS   = 35;
  localparam int FADE_SPAN3    = (RING_PIXELS - 1) * (RING_PIXELS - 1) * (RING_PIXELS - 1);
  localparam int LATENCY_SLACK = 40;       // command-to-first-pixel latency plus margin
  localparam int IDLE_PERCENT  = 11;
  localparam int MAX_PRINTED   = 100;      // cap mismatch lines, keep counting

  // Register byte addresses: word i sits at 4*i. The spare word has no register.
  localparam logic [CFG_AW-1:0] SCALE_ADDR = CFG_AW'(4 * REG_GAIN);
  localparam logic [CFG_AW-1:0] SPARE_ADDR = SCALE_ADDR + CFG_AW'(4);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       blue;
    logic             last;
  } pixel_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_head_position;
  logic [7:0]          in_frame_brightness;
  logic [7:0]          in_color_select;
  logic                out_valid;
  logic                out_ready;
  logic [PIX_W-1:0]    out_pixel_number;
  logic [7:0]          out_green_level;
  logic [7:0]          out_red_level;
  logic [7:0]          out_blue_level;
  logic                out_last_pixel;

  // Palette as {R, G, B}, indexed by the low three selector bits.
  logic [23:0] base_rgb [8] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFA500,
                                24'h8000FF, 24'h00FFC8, 24'hFFFF00, 24'hFF1493};

  logic [7:0] scale_shadow;                // mirror of the brightness scale register
  pixel_t     expected_pixels [$];         // pixels still owed by the renderer, in order
  pixel_t     want_px;
  int         mismatch_count = 0;
  bit         idle_on = 1'b1;              // clear for a stretch with no idling on either side

  comet_ring_frame_renderer_top #(
    .RING_PIXELS(RING_PIXELS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_head_position   (in_head_position),
    .in_frame_brightness(in_frame_brightness),
    .in_color_select    (in_color_select),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_number   (out_pixel_number),
    .out_green_level    (out_green_level),
    .out_red_level      (out_red_level),
    .out_blue_level     (out_blue_level),
    .out_last_pixel     (out_last_pixel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("comet_ring_frame_renderer_top_test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR: %s expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // Queue up the whole ring for one frame command, using the scale at acceptance.
  function automatic void predict_frame(input logic [7:0] head, input logic [7:0] bright,
                                        input logic [7:0] sel);
    int unsigned pos, br, gap, drop, level;
    logic [23:0] base;
    pixel_t      px;
    pos  = head;
    br   = bright;
    br   = (br * scale_shadow) >> 8;
    base = base_rgb[sel[2:0]];
    for (int i = 0; i < RING_PIXELS; i++) begin
      // Clockwise distance from the head; the head wraps modulo the ring size.
      gap   = (pos + RING_PIXELS - i) % RING_PIXELS;
      drop  = (gap * gap * gap * br) / FADE_SPAN3;
      level = (drop > br) ? 0 : br - drop;
      px.pixel = PIX_W'(i);
      px.green = 8'((base[15:8] * level) >> 8);
      px.red   = 8'((base[23:16] * level) >> 8);
      px.blue  = 8'((base[7:0] * level) >> 8);
      px.last  = (i == RING_PIXELS - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  // Result side: stall at random, except during the calm stretch.
  always @(posedge clk)
    out_ready <= !(idle_on && ($urandom_range(0, 99) < IDLE_PERCENT));

  // Sample at the falling edge: a transaction seen here completes at the next rising edge,
  // and nothing it depends on moves in between.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d", out_pixel_number), 0, 1);
      end else begin
        want_px = expected_pixels.pop_front();
        if (out_pixel_number !== want_px.pixel)
          report_mismatch("pixel number", want_px.pixel, out_pixel_number);
        if (out_green_level !== want_px.green)
          report_mismatch($sformatf("pixel %0d green", want_px.pixel), want_px.green,
                          out_green_level);
        if (out_red_level !== want_px.red)
          report_mismatch($sformatf("pixel %0d red", want_px.pixel), want_px.red,
                          out_red_level);
        if (out_blue_level !== want_px.blue)
          report_mismatch($sformatf("pixel %0d blue", want_px.pixel), want_px.blue,
                          out_blue_level);
        if (out_last_pixel !== want_px.last)
          report_mismatch($sformatf("pixel %0d last flag", want_px.pixel), want_px.last,
                          out_last_pixel);
      end
    end
  end

  // Present one frame command and hold it until accepted. Returns in the step of the
  // accepting edge with valid still high, so a following send keeps it high unless it idles first.
  task automatic send_frame(input logic [7:0] head, input logic [7:0] bright,
                            input logic [7:0] sel);
    if (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_head_position    <= head;
    in_frame_brightness <= bright;
    in_color_select     <= sel;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_frame(head, bright, sel);
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline run dry.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_scale_readback();
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, SCALE_ADDR, '0, rd);
    if (rd !== CFG_DW'(scale_shadow))
      report_mismatch("scale register readback", scale_shadow, rd);
  endtask

  // Write a word with random upper bits; only the low byte of the scale word counts.
  task automatic write_config(input logic [CFG_AW-1:0] addr, input logic [7:0] value);
    logic [CFG_DW-1:0] rd;
    logic [CFG_DW-1:0] word;
    word = {24'($urandom()), value};
    wait_for_idle();
    cfg_access(1'b1, addr, word, rd);
    if (addr == SCALE_ADDR) scale_shadow = value;
    check_scale_readback();
  endtask

  task automatic test_reset_readback();
    scale_shadow = SCALE_RESET;
    check_scale_readback();
  endtask

  // Head extremes and wrap, brightness extremes, every palette entry, wide selectors.
  task automatic test_directed_frames();
    send_frame(8'd0, 8'd255, 8'd0);
    send_frame(8'(RING_PIXELS - 1), 8'd255, 8'd1);
    send_frame(8'(RING_PIXELS), 8'd255, 8'd2);       // wraps to pixel 0
    send_frame(8'd255, 8'd255, 8'd3);
    send_frame(8'd17, 8'd0, 8'd4);
    send_frame(8'd9, 8'd1, 8'd5);
    for (int c = 0; c < 8; c++)
      send_frame(8'($urandom_range(0, RING_PIXELS - 1)), 8'd255,
                 8'(c + 8 * $urandom_range(0, 31)));
    send_frame(8'd200, 8'd128, 8'hFF);
    wait_for_idle();
  endtask

  // Scale extremes, and a write to a word with no register behind it.
  task automatic test_scale_extremes();
    write_config(SCALE_ADDR, 8'd0);
    send_frame(8'd3, 8'd255, 8'd7);
    send_frame(8'd100, 8'd200, 8'd1);
    write_config(SCALE_ADDR, 8'd255);
    send_frame(8'd0, 8'd255, 8'd0);
    send_frame(8'(RING_PIXELS - 1), 8'd255, 8'd6);
    send_frame(8'd34, 8'd254, 8'd5);
    write_config(SCALE_ADDR, 8'd1);
    send_frame(8'd12, 8'd255, 8'd3);
    write_config(SPARE_ADDR, 8'hA5);               // must leave the scale at 1
    send_frame(8'd20, 8'd255, 8'd4);
    wait_for_idle();
  endtask

  // Random frames in several scale phases; one phase runs with no idling at all.
  task automatic test_random_frames();
    logic [7:0] head;
    for (int phase = 0; phase < 4; phase++) begin
      write_config(SCALE_ADDR, (phase == 2) ? 8'd128 : 8'($urandom_range(0, 255)));
      idle_on = (phase != 1);
      for (int n = 0; n < 105; n++) begin
        head = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, RING_PIXELS - 1))
                                            : 8'($urandom_range(0, 255));
        send_frame(head, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    idle_on = 1'b1;
    wait_for_idle();
  endtask

  // Hold the sender until the whole ring of the previous frame is out.
  task automatic test_drain_between_frames();
    for (int n = 0; n < 6; n++) begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      in_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clk);
    end
    wait_for_idle();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_head_position    = '0;
    in_frame_brightness = '0;
    in_color_select     = '0;
    out_ready           = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    scale_shadow        = SCALE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_readback();
    test_directed_frames();
    test_scale_extremes();
    test_random_frames();
    test_drain_between_frames();

    if (mismatch_count == 0) begin
      $display("comet_ring_frame_renderer_top_test passed");
    end else begin
      $display("comet_ring_frame_renderer_top_test failed");
    end
    $finish;
  end

endmodule
